// File: hdl/assert_macros.svh
// assertion macros, compiled away when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: hdl/gmb_pkg.sv
// ---------------------------------------------------------------------------
// gmb_pkg
// shared types and constants of the maze backtracker
// ---------------------------------------------------------------------------
package gmb_pkg;
	localparam int         MAX_DIM   = 64;
	localparam logic [1:0] CELL_OPEN = 2'd0;
	localparam logic [1:0] CELL_WALL = 2'd1;
	localparam logic [1:0] CELL_GOAL = 2'd2;
	localparam logic       ACT_GEN   = 1'b0;
	localparam logic       ACT_READ  = 1'b1;
	localparam logic       REG_ROWS  = 1'b0;
	localparam logic       REG_COLS  = 1'b1;

	typedef struct packed {
		logic        action;
		logic [5:0]  cell_row;
		logic [5:0]  cell_col;
		logic [31:0] seed;
	} gmb_in_t;

	typedef struct packed {
		logic [1:0] cell_state;
		logic [5:0] start_row;
		logic [5:0] start_col;
		logic       status;
	} gmb_out_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RDWAIT, ST_FILL, ST_POP, ST_POPWAIT, ST_SHUF,
		ST_PROBE, ST_PROBEWAIT, ST_CHECK, ST_PUSHCUR, ST_OPENWALL, ST_OPENNB,
		ST_PUSHNB, ST_DONE
	} gmb_state_t;

	function automatic logic [31:0] xs32(input logic [31:0] x);
		logic [31:0] a, b;
		a = x ^ (x << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

	// remainder by three: fold at powers of four, each congruent to one
	function automatic logic [1:0] mod3_u32(input logic [31:0] x);
		logic [16:0] a;
		logic [9:0]  b;
		logic [6:0]  c;
		logic [4:0]  d;
		logic [2:0]  e;
		logic [2:0]  f;
		a = {1'b0, x[31:16]} + {1'b0, x[15:0]};
		b = {1'b0, a[16:8]} + {2'b0, a[7:0]};
		c = {1'b0, b[9:4]} + {3'b0, b[3:0]};
		d = c[6:2] + {3'b0, c[1:0]};
		e = d[4:2] + {1'b0, d[1:0]};
		f = {2'b0, e[2]} + {1'b0, e[1:0]};
		return (f >= 3'd3) ? 2'(f - 3'd3) : f[1:0];
	endfunction
endpackage

// File: hdl/gmb_ram.sv
// ---------------------------------------------------------------------------
// gmb_ram
// single port synchronous ram, registered read
// ---------------------------------------------------------------------------
module gmb_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// File: hdl/grid_maze_backtracker_top.sv
// ---------------------------------------------------------------------------
// grid_maze_backtracker_top
// depth first maze carving over a cell ram and an explicit walk stack ram
// ---------------------------------------------------------------------------
// channel | direction | handshake            | word
// request | in        | start & !busy        | gmb_in_t
// result  | out       | done strobe, 1 cycle | gmb_out_t
// config  | in        | cfg_valid&cfg_ready  | index + 7 bit data
// read: the word passes ST_RDWAIT, the strobe shows in ST_DONE, and the next word is taken in ST_IDLE
// generate: all rows*cols cells are filled as walls, then the goal is pushed;
//   each pop shuffles the moves, skips neighbours off the grid, probes the rest in
//   the ram and carves each wall found; an empty pop ends it; rams are single-port
// reset clears control and the start cell and sets the random word to 1; rams are not cleared
// a bad request strobes done in the cycle after it is taken; the receiver cannot stall
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module grid_maze_backtracker_top import gmb_pkg::*; #(
	parameter int STACK_DEPTH = 2048
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  gmb_in_t    req,
	output logic       done,
	output gmb_out_t   rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data
);
	localparam int DW = $clog2(MAX_DIM);
	localparam int AW = 2 * DW;
	localparam int SW = $clog2(STACK_DEPTH);
	localparam int CW = SW + 1;
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int MW = DW + 2;
	localparam logic signed [DW+2:0] STEP2 = (DW+3)'(2);

	gmb_state_t st_q, st_d;
	logic [6:0] rows_reg_q, cols_reg_q;
	logic [DW:0] rows_q, cols_q;          // effective sizes
	logic [DW-1:0] gr_q, gc_q, cr_q, cc_q, nr_q, nc_q, fr_q, fc_q;
	logic [DW-1:0] fill_r_q, fill_c_q;
	logic [31:0] rng_q;
	logic [7:0] ord_q;                    // four 2 bit moves
	logic [1:0] shuf_i_q, k_q;
	logic [CW-1:0] sp_q;
	logic [2*MW:0] best_q;
	gmb_out_t rsp_q;
	logic done_q;

	// goal written right after the fill sweep
	logic first_q;
	wire goal_wr = (st_q == ST_PUSHNB) && first_q;

	// cell ram port
	logic c_we;
	logic [AW-1:0] c_addr;
	logic [1:0] c_wd, c_rd;
	// stack ram port
	logic s_we;
	logic [SW-1:0] s_addr;
	logic [2*DW-1:0] s_wd, s_rd;

	gmb_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_cells (
		.clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd));
	gmb_ram #(.WIDTH(2*DW), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));

	function automatic logic [DW:0] eff(input logic [6:0] v);
		logic [7:0] lim;
		lim = 8'(MAX_DIM);
		return ({1'b0, v} > lim) ? (DW+1)'(MAX_DIM) : (DW+1)'(v);
	endfunction

	assign rows_q = eff(rows_reg_q);
	assign cols_q = eff(cols_reg_q);
	assign cfg_ready = (st_q == ST_IDLE);
	assign busy = (st_q != ST_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;

	wire accept = start && !busy;
	wire in_grid = ({1'b0, DW'(req.cell_row)} < rows_q) && ({1'b0, DW'(req.cell_col)} < cols_q);

	// current move and neighbour candidate
	logic [1:0] mv;
	logic signed [DW+2:0] cand_r, cand_c;
	logic cand_ok;
	assign mv = ord_q[2*k_q +: 2];
	always_comb begin
		cand_r = $signed({3'b0, cr_q});
		cand_c = $signed({3'b0, cc_q});
		case (mv)
			2'd0: cand_r = cand_r + STEP2;
			2'd1: cand_r = cand_r - STEP2;
			2'd2: cand_c = cand_c + STEP2;
			default: cand_c = cand_c - STEP2;
		endcase
		cand_ok = (cand_r >= 0) && (cand_c >= 0) && (cand_r < $signed({2'b0, rows_q}))
			&& (cand_c < $signed({2'b0, cols_q}));
	end

	// shuffle: j = rand % (i+1) for i = 3,2,1
	logic [31:0] rnext;
	logic [1:0] sj;
	logic [7:0] ord_sw;
	assign rnext = xs32(rng_q);
	always_comb begin
		logic [1:0] ti, tj;
		case (shuf_i_q)
			2'd3: sj = rnext[1:0];
			2'd2: sj = mod3_u32(rnext);
			default: sj = {1'b0, rnext[0]};
		endcase
		ord_sw = ord_q;
		ti = ord_q[2*shuf_i_q +: 2];
		tj = ord_q[2*sj +: 2];
		ord_sw[2*shuf_i_q +: 2] = tj;
		ord_sw[2*sj +: 2] = ti;
	end

	// squared distance of the neighbour to the goal
	logic [DW-1:0] adr, adc;
	logic [2*MW:0] sq_dist;
	assign adr = (gr_q > nr_q) ? gr_q - nr_q : nr_q - gr_q;
	assign adc = (gc_q > nc_q) ? gc_q - nc_q : nc_q - gc_q;
	assign sq_dist = (2*MW+1)'(adr * adr) + (2*MW+1)'(adc * adc);

	wire stack_full = (sp_q == CW'(STACK_DEPTH));

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (accept) begin
				if (req.action == ACT_READ) st_d = in_grid ? ST_RDWAIT : ST_DONE;
				else if (in_grid && !req.cell_row[0] && !req.cell_col[0]) st_d = ST_FILL;
				else st_d = ST_DONE;
			end
			ST_RDWAIT: st_d = ST_DONE;
			ST_FILL: if ({1'b0, fill_r_q} == rows_q - 1'b1 && {1'b0, fill_c_q} == cols_q - 1'b1)
				st_d = ST_PUSHNB;
			ST_POP: st_d = (sp_q == '0) ? ST_DONE : ST_POPWAIT;
			ST_POPWAIT: st_d = ST_SHUF;
			ST_SHUF: if (shuf_i_q == 2'd1) st_d = ST_PROBE;
			ST_PROBE: st_d = cand_ok ? ST_PROBEWAIT : (k_q == 2'd3 ? ST_POP : ST_PROBE);
			ST_PROBEWAIT: st_d = ST_CHECK;
			ST_CHECK: st_d = (c_rd == CELL_WALL) ? ST_PUSHCUR : (k_q == 2'd3 ? ST_POP : ST_PROBE);
			ST_PUSHCUR: st_d = ST_OPENWALL;
			ST_OPENWALL: st_d = ST_OPENNB;
			ST_OPENNB: st_d = ST_PUSHNB;
			ST_PUSHNB: st_d = ST_POP;
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		c_we = 1'b0; c_wd = CELL_WALL;
		c_addr = {DW'(req.cell_row), DW'(req.cell_col)};
		s_we = 1'b0; s_wd = {cr_q, cc_q};
		s_addr = SW'(sp_q - 1'b1);
		case (st_q)
			ST_FILL: begin
				c_we = 1'b1; c_addr = {fill_r_q, fill_c_q};
				if ({1'b0, fill_r_q} == rows_q - 1'b1 && {1'b0, fill_c_q} == cols_q - 1'b1) begin
					// last fill cell; goal written in the push cycle
				end
			end
			ST_PROBE: c_addr = {DW'(cand_r), DW'(cand_c)};
			// hold the probe address so the check cycle sees its cell
			ST_PROBEWAIT: c_addr = {nr_q, nc_q};
			ST_PUSHCUR: begin
				s_we = !stack_full; s_addr = SW'(sp_q); s_wd = {cr_q, cc_q};
			end
			ST_OPENWALL: begin
				c_we = 1'b1; c_wd = CELL_OPEN;
				c_addr = {DW'(({1'b0, cr_q} + {1'b0, nr_q}) >> 1),
					DW'(({1'b0, cc_q} + {1'b0, nc_q}) >> 1)};
			end
			ST_OPENNB: begin
				c_we = 1'b1; c_wd = CELL_OPEN; c_addr = {nr_q, nc_q};
			end
			ST_PUSHNB: begin
				s_we = !stack_full; s_addr = SW'(sp_q); s_wd = {nr_q, nc_q};
				if (goal_wr) begin
					c_we = 1'b1; c_wd = CELL_GOAL; c_addr = {gr_q, gc_q};
				end
			end
			default: ;
		endcase
	end

	// wall/open halfway cell uses full width sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			rows_reg_q <= 7'd64; cols_reg_q <= 7'd64;
			fr_q <= '0; fc_q <= '0;
			rng_q <= 32'd1;
			sp_q <= '0;
			done_q <= 1'b0;
			first_q <= 1'b0;
		end else begin
			st_q <= st_d;
			done_q <= (st_d == ST_DONE);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ROWS) rows_reg_q <= cfg_data;
				else cols_reg_q <= cfg_data;
			end
			case (st_q)
				ST_IDLE: if (accept) begin
					rsp_q.cell_state <= CELL_OPEN;
					rsp_q.status <= 1'b1;
					if (req.action == ACT_READ) begin
						rsp_q.status <= !in_grid;
					end else if (in_grid && !req.cell_row[0] && !req.cell_col[0]) begin
						rsp_q.status <= 1'b0;
						rng_q <= req.seed;
						gr_q <= DW'(req.cell_row); gc_q <= DW'(req.cell_col);
						nr_q <= DW'(req.cell_row); nc_q <= DW'(req.cell_col);
						fr_q <= DW'(req.cell_row); fc_q <= DW'(req.cell_col);
						fill_r_q <= '0; fill_c_q <= '0;
						best_q <= '0; sp_q <= '0;
						ord_q <= {2'd3, 2'd2, 2'd1, 2'd0};
						first_q <= 1'b1;
					end
				end
				ST_RDWAIT: rsp_q.cell_state <= c_rd;
				ST_FILL: begin
					if ({1'b0, fill_c_q} == cols_q - 1'b1) begin
						fill_c_q <= '0; fill_r_q <= fill_r_q + 1'b1;
					end else fill_c_q <= fill_c_q + 1'b1;
				end
				ST_POP: if (sp_q != '0) sp_q <= sp_q - 1'b1;
				ST_POPWAIT: begin
					shuf_i_q <= 2'd3;
					cr_q <= s_rd[2*DW-1:DW]; cc_q <= s_rd[DW-1:0];
				end
				ST_SHUF: begin
					rng_q <= rnext; ord_q <= ord_sw;
					shuf_i_q <= shuf_i_q - 1'b1;
					k_q <= '0;
				end
				ST_PROBE: begin
					nr_q <= DW'(cand_r); nc_q <= DW'(cand_c);
					if (!cand_ok) k_q <= k_q + 1'b1;
				end
				ST_CHECK: if (c_rd != CELL_WALL) k_q <= k_q + 1'b1;
				ST_PUSHCUR: if (!stack_full) sp_q <= sp_q + 1'b1;
				ST_OPENNB: if (sq_dist > best_q) begin
					best_q <= sq_dist; fr_q <= nr_q; fc_q <= nc_q;
				end
				ST_PUSHNB: begin
					if (!stack_full) sp_q <= sp_q + 1'b1;
					first_q <= 1'b0;
				end
				default: ;
			endcase
			if (st_d == ST_DONE) begin
				rsp_q.start_row <= 6'(fr_q);
				rsp_q.start_col <= 6'(fc_q);
			end
		end
	end

	`ASSERT_NEVER(a_cfg_busy, clk, arst_n, cfg_ready && busy, "config taken while busy")
	`ASSERT_IMPL(a_done_pulse, clk, arst_n, done |=> !done, "result strobe longer than one cycle")
	`ASSERT_IMPL(a_sp_bound, clk, arst_n, sp_q <= CW'(STACK_DEPTH), "stack pointer past depth")
	`ASSERT_IMPL(a_done_state, clk, arst_n, done |-> (st_q == ST_DONE), "strobe outside done state")
endmodule
